@@ hw/rtl/wbt_pkg.sv @@
// Shared types and constants of the work/break interval timer.
package wbt_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] CFG_WORK_SECONDS       = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_BREAK_SECONDS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_BREAK_SECONDS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_BREAK_EVERY   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS        = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FLASH_HALF_MS      = 3'd5;

	localparam logic [15:0] WORK_SECONDS_RST       = 16'd1500;
	localparam logic [15:0] BREAK_SECONDS_RST      = 16'd300;
	localparam logic [15:0] LONG_BREAK_SECONDS_RST = 16'd1500;
	localparam logic [4:0]  LONG_BREAK_EVERY_RST   = 5'd4;
	localparam logic [9:0]  DEBOUNCE_MS_RST        = 10'd250;
	localparam logic [9:0]  FLASH_HALF_MS_RST      = 10'd250;

	localparam logic [9:0]  DEBOUNCE_CAP  = 10'd1000;
	localparam logic [9:0]  LOCKOUT_SAT   = 10'd1023;
	localparam logic [9:0]  MINUTES_MAX   = 10'd999;
	localparam logic [25:0] MS_PER_SEC    = 26'd1000;
	localparam logic [22:0] SEC_PER_MIN   = 23'd60;

	// floor(x / 1000) = (x * RECIP_1000) >> 38 for any 32-bit x
	localparam logic [28:0] RECIP_1000 = 29'd274877907;
	// floor(x / 60) = (x * RECIP_60) >> 29 for any 23-bit x
	localparam logic [23:0] RECIP_60   = 24'd8947849;

	typedef enum logic [1:0] {
		PH_STANDBY = 2'd0,
		PH_WORK    = 2'd1,
		PH_BREAK   = 2'd2
	} phase_t;

	typedef struct packed {
		logic button_level;
	} tick_t;

	typedef struct packed {
		logic [1:0]  phase;
		logic [15:0] round_number;
		logic [9:0]  minutes;
		logic [5:0]  seconds;
		logic        overtime;
		logic        paused;
		logic        paused_flash;
		logic        buzzer;
	} status_t;

endpackage

@@ hw/rtl/wbt_stream_if.sv @@
// Valid/ready stream channel carrying one payload per transfer.
interface wbt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
	modport monitor (input valid, input ready, input payload);
endinterface

@@ hw/rtl/work_break_interval_timer.sv @@
// Work/break interval timer: one tick transfer in, one status transfer out, status registered in
// s1 to s4 and out_q; one tick accepted every cycle while the status side takes results and no
// rebuild runs; state updates in the first stage, the time readout is formed over the next stages
// by two reciprocal multipliers (divide by 1000, then by 60); writing long_break_every blocks
// ticks while a bit-serial remainder rebuilds the round count modulo that register.
module work_break_interval_timer (
	input  logic                         clk,
	input  logic                         arst_n,
	wbt_stream_if.sink                   tick,
	wbt_stream_if.source                 status,
	input  logic                         cfg_we,
	input  logic [wbt_pkg::CFG_IDX_W-1:0]  cfg_idx,
	input  logic [wbt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import wbt_pkg::*;

	typedef struct packed {
		logic        active;
		logic [1:0]  phase;
		logic [15:0] round_number;
		logic        overtime;
		logic        paused;
		logic        flash_on;
	} ctl_t;

	// configuration
	logic [15:0] work_seconds_q, break_seconds_q, long_break_seconds_q;
	logic [4:0]  long_break_every_q;
	logic [9:0]  debounce_ms_q, flash_half_ms_q;

	// timer state
	phase_t      phase_q;
	logic [15:0] round_q;
	logic [4:0]  round_res_q;
	logic [31:0] elapsed_q;
	logic        paused_q;
	logic        lockout_q;
	logic [9:0]  lockout_ms_q;
	logic [10:0] flash_ms_q;
	logic        mod_busy_q;
	logic [3:0]  mod_cnt_q;

	// pipeline
	logic        v_s1, v_s2, v_s3, v_s4, out_v_q;
	ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic [31:0] el_s1;
	logic [25:0] len_s1;
	logic [31:0] mag_s2;
	logic [22:0] tot_s3, tot_s4;
	logic [16:0] min_s4;
	status_t     out_q;

	logic        adv, accept;
	logic [4:0]  every_eff;
	logic [9:0]  half, deb;
	logic        active, long_sel, press, entered, ot_pre, ot_post, flash_on;
	logic [15:0] len_cur_s, len_new_s;
	logic [25:0] len_cur_ms, len_new_ms;
	logic [31:0] elapsed_inc;
	logic [9:0]  lock_ms_inc;
	phase_t      phase_n;
	logic [15:0] round_n;
	logic [4:0]  res_n, res_inc;
	logic [31:0] elapsed_n;
	logic        paused_n, lockout_n;
	logic [9:0]  lock_ms_n;
	logic [11:0] flash_inc;
	logic [10:0] flash_n;
	logic [5:0]  mod_r2;
	logic [4:0]  mod_rem;
	logic [60:0] prod_ms;
	logic [46:0] prod_min;
	logic [22:0] sec_total;

	assign adv        = !out_v_q || status.ready;
	assign tick.ready = adv && !mod_busy_q;
	assign accept     = tick.valid && tick.ready;

	assign every_eff = (long_break_every_q == 5'd0) ? 5'd1 : long_break_every_q;
	assign half      = (flash_half_ms_q == 10'd0) ? 10'd1 : flash_half_ms_q;
	assign deb       = (debounce_ms_q > DEBOUNCE_CAP) ? DEBOUNCE_CAP : debounce_ms_q;
	assign active    = (phase_q == PH_WORK) || (phase_q == PH_BREAK);
	assign long_sel  = (round_res_q == 5'd0);

	always_comb begin
		case (phase_q)
			PH_WORK:  len_cur_s = work_seconds_q;
			PH_BREAK: len_cur_s = long_sel ? long_break_seconds_q : break_seconds_q;
			default:  len_cur_s = 16'd0;
		endcase
	end

	assign len_cur_ms  = 26'(len_cur_s) * MS_PER_SEC;
	assign elapsed_inc = (active && !paused_q && (elapsed_q != '1)) ? elapsed_q + 32'd1
		: elapsed_q;
	assign lock_ms_inc = (lockout_q && (lockout_ms_q != LOCKOUT_SAT)) ? lockout_ms_q + 10'd1
		: lockout_ms_q;
	assign ot_pre      = active && (elapsed_inc > 32'(len_cur_ms));
	assign press       = tick.payload.button_level && !lockout_q;
	assign res_inc     = round_res_q + 5'd1;

	always_comb begin
		phase_n   = phase_q;
		round_n   = round_q;
		res_n     = round_res_q;
		elapsed_n = elapsed_inc;
		paused_n  = paused_q;
		lockout_n = lockout_q;
		lock_ms_n = lock_ms_inc;
		entered   = 1'b0;
		if (press) begin
			lockout_n = 1'b1;
			lock_ms_n = 10'd0;
			if (!active) begin
				phase_n = PH_WORK;
				entered = 1'b1;
			end else if (ot_pre) begin
				phase_n = (phase_q == PH_WORK) ? PH_BREAK : PH_WORK;
				entered = 1'b1;
			end else begin
				paused_n = !paused_q;
			end
		end else if (lockout_q && (lock_ms_inc > deb)) begin
			lockout_n = 1'b0;
		end
		if (entered) begin
			elapsed_n = 32'd0;
			paused_n  = 1'b0;
			if (phase_n == PH_WORK) begin
				round_n = round_q + 16'd1;
				if (round_n == 16'd0) begin
					res_n = 5'd0;
				end else begin
					res_n = (res_inc == every_eff) ? 5'd0 : res_inc;
				end
			end
		end
	end

	assign ot_post = entered ? 1'b0 : ot_pre;

	always_comb begin
		case (phase_n)
			PH_WORK:  len_new_s = work_seconds_q;
			PH_BREAK: len_new_s = long_sel ? long_break_seconds_q : break_seconds_q;
			default:  len_new_s = 16'd0;
		endcase
	end

	assign len_new_ms = 26'(len_new_s) * MS_PER_SEC;
	assign flash_on   = flash_ms_q < {1'b0, half};
	assign flash_inc  = 12'(flash_ms_q) + 12'd1;
	assign flash_n    = (flash_inc >= {1'b0, half, 1'b0}) ? 11'd0 : flash_inc[10:0];

	// bit-serial remainder of the round count by the long-break modulus
	assign mod_r2  = {round_res_q, round_q[mod_cnt_q]};
	assign mod_rem = (mod_r2 >= {1'b0, every_eff}) ? 5'(mod_r2 - {1'b0, every_eff})
		: mod_r2[4:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			work_seconds_q       <= WORK_SECONDS_RST;
			break_seconds_q      <= BREAK_SECONDS_RST;
			long_break_seconds_q <= LONG_BREAK_SECONDS_RST;
			long_break_every_q   <= LONG_BREAK_EVERY_RST;
			debounce_ms_q        <= DEBOUNCE_MS_RST;
			flash_half_ms_q      <= FLASH_HALF_MS_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_WORK_SECONDS:       work_seconds_q       <= cfg_wdata;
				CFG_BREAK_SECONDS:      break_seconds_q      <= cfg_wdata;
				CFG_LONG_BREAK_SECONDS: long_break_seconds_q <= cfg_wdata;
				CFG_LONG_BREAK_EVERY:   long_break_every_q   <= cfg_wdata[4:0];
				CFG_DEBOUNCE_MS:        debounce_ms_q        <= cfg_wdata[9:0];
				CFG_FLASH_HALF_MS:      flash_half_ms_q      <= cfg_wdata[9:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_STANDBY;
			round_q      <= 16'd0;
			round_res_q  <= 5'd0;
			elapsed_q    <= 32'd0;
			paused_q     <= 1'b0;
			lockout_q    <= 1'b0;
			lockout_ms_q <= 10'd0;
			flash_ms_q   <= 11'd0;
			mod_busy_q   <= 1'b0;
			mod_cnt_q    <= 4'd0;
		end else begin
			if (cfg_we && (cfg_idx == CFG_LONG_BREAK_EVERY)) begin
				mod_busy_q  <= 1'b1;
				mod_cnt_q   <= '1;
				round_res_q <= 5'd0;
			end else if (mod_busy_q) begin
				round_res_q <= mod_rem;
				mod_cnt_q   <= mod_cnt_q - 4'd1;
				if (mod_cnt_q == 4'd0) begin
					mod_busy_q <= 1'b0;
				end
			end else if (accept) begin
				round_res_q <= res_n;
			end
			if (accept) begin
				phase_q      <= phase_n;
				round_q      <= round_n;
				elapsed_q    <= elapsed_n;
				paused_q     <= paused_n;
				lockout_q    <= lockout_n;
				lockout_ms_q <= lock_ms_n;
				flash_ms_q   <= flash_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			v_s3    <= 1'b0;
			v_s4    <= 1'b0;
			out_v_q <= 1'b0;
		end else if (adv) begin
			v_s1    <= accept;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			v_s4    <= v_s3;
			out_v_q <= v_s4;
		end
	end

	assign prod_ms   = 61'(mag_s2) * 61'(RECIP_1000);
	assign prod_min  = 47'(tot_s3) * 47'(RECIP_60);
	assign sec_total = tot_s4 - 23'(min_s4) * SEC_PER_MIN;

	always_ff @(posedge clk) begin
		if (adv) begin
			ctl_s1.active       <= (phase_n == PH_WORK) || (phase_n == PH_BREAK);
			ctl_s1.phase        <= phase_n;
			ctl_s1.round_number <= round_n;
			ctl_s1.overtime     <= ot_post;
			ctl_s1.paused       <= paused_n;
			ctl_s1.flash_on     <= flash_on;
			el_s1               <= elapsed_n;
			len_s1              <= len_new_ms;

			ctl_s2 <= ctl_s1;
			mag_s2 <= ctl_s1.overtime ? el_s1 - 32'(len_s1) : 32'(len_s1) - el_s1;

			ctl_s3 <= ctl_s2;
			tot_s3 <= prod_ms[60:38];

			ctl_s4 <= ctl_s3;
			tot_s4 <= tot_s3;
			min_s4 <= prod_min[45:29];

			out_q.phase        <= ctl_s4.active ? ctl_s4.phase : PH_STANDBY;
			out_q.round_number <= ctl_s4.round_number;
			out_q.minutes      <= !ctl_s4.active ? 10'd0
				: (min_s4 > 17'(MINUTES_MAX)) ? MINUTES_MAX : min_s4[9:0];
			out_q.seconds      <= ctl_s4.active ? sec_total[5:0] : 6'd0;
			out_q.overtime     <= ctl_s4.active && ctl_s4.overtime;
			out_q.paused       <= ctl_s4.active && ctl_s4.paused;
			out_q.paused_flash <= ctl_s4.active && ctl_s4.paused && ctl_s4.flash_on;
			out_q.buzzer       <= ctl_s4.active && ctl_s4.overtime && ctl_s4.flash_on;
		end
	end

	assign status.valid   = out_v_q;
	assign status.payload = out_q;

endmodule

@@ hw/rtl/wbt_checker.sv @@
// Port-level checks of the interval timer and their binding to the top level.
module wbt_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             status_valid,
	input logic             status_ready,
	input wbt_pkg::status_t status_payload
);
	import wbt_pkg::*;

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && !status_ready |=> status_valid)
		else $error("status transfer dropped while stalled");

	a_standby_zero: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid && (status_payload.phase == PH_STANDBY) |->
		(status_payload.minutes == 10'd0) && (status_payload.seconds == 6'd0) &&
		!status_payload.overtime && !status_payload.paused)
		else $error("standby status carries timing fields");

	a_readout_range: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> (status_payload.seconds <= 6'd59) &&
		(status_payload.minutes <= MINUTES_MAX))
		else $error("time readout out of range");

	a_flash_flags: assert property (@(posedge clk) disable iff (!arst_n)
		status_valid |-> (!status_payload.buzzer || status_payload.overtime) &&
		(!status_payload.paused_flash || status_payload.paused))
		else $error("flash output without its flag");

endmodule

bind work_break_interval_timer wbt_checker u_wbt_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.status_valid   (status.valid),
	.status_ready   (status.ready),
	.status_payload (status.payload)
);
